[hw/rtl/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants, types and helpers of the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // frame store size in bytes, split over an even and an odd byte bank
  localparam int FRAME_BYTES = 64;
  localparam int BANK_DEPTH  = (FRAME_BYTES + 1) / 2;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // store index: header 0..3, payload and sum byte up to 4 + 49
  localparam int WR_IDX_W  = 6;
  localparam int IDX_CMP_W = 9;

  // frame syntax
  localparam logic [7:0] SYNC_0     = 8'hAA;
  localparam logic [7:0] SYNC_1     = 8'hAF;
  localparam logic [7:0] CMD_LIMIT  = 8'hF1;
  localparam logic [7:0] LEN_LIMIT  = 8'd50;
  localparam logic [7:0] CMD_COEF_LO = 8'h10;
  localparam logic [7:0] CMD_COEF_HI = 8'h15;

  // acknowledge frame
  localparam logic [7:0] ACK_HDR_0 = 8'hAA;
  localparam logic [7:0] ACK_HDR_1 = 8'hAA;
  localparam logic [7:0] ACK_HDR_2 = 8'hEF;
  localparam logic [7:0] ACK_HDR_3 = 8'h02;
  localparam logic [7:0] ACK_SUM_BASE =
    8'((32'(ACK_HDR_0) + 32'(ACK_HDR_1) + 32'(ACK_HDR_2) + 32'(ACK_HDR_3)) & 32'hFF);

  // result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_COEF    = 2'd2;

  // result sequence steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_ACK_CMD   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_ACK_SUM   = 5'd5;
  localparam logic [STEP_W-1:0] STEP_ACK_CHK   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_VERDICT   = 5'd7;
  localparam logic [STEP_W-1:0] STEP_COEF_0    = 5'd8;
  localparam logic [STEP_W-1:0] STEP_COEF_LAST = 5'd16;

  // coefficient c sits at byte 2c+4, i.e. word c+2 of each bank
  localparam int COEF_ADDR_BASE = 2;

  // one write into a byte bank
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         data;
  } bank_wr_t;

  // completed frame handed to the result sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] cmd;
    logic [7:0] sum_byte;
    logic       ok;
  } frame_done_t;

  typedef struct packed {
    logic [1:0] row_off;
    logic [1:0] col;
  } coef_pos_t;

  // coefficient number to row offset and column
  function automatic coef_pos_t coef_pos(input logic [3:0] c);
    coef_pos_t p;
    p = '0;
    case (c)
      4'd0: begin p.row_off = 2'd0; p.col = 2'd0; end
      4'd1: begin p.row_off = 2'd0; p.col = 2'd1; end
      4'd2: begin p.row_off = 2'd0; p.col = 2'd2; end
      4'd3: begin p.row_off = 2'd1; p.col = 2'd0; end
      4'd4: begin p.row_off = 2'd1; p.col = 2'd1; end
      4'd5: begin p.row_off = 2'd1; p.col = 2'd2; end
      4'd6: begin p.row_off = 2'd2; p.col = 2'd0; end
      4'd7: begin p.row_off = 2'd2; p.col = 2'd1; end
      4'd8: begin p.row_off = 2'd2; p.col = 2'd2; end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/cfr_ram.sv]
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/cfr_bank.sv]
// ----------------------------------------------------------------------------
// cfr_bank
// One byte bank of the frame store: RAM plus per-entry written flags, so
// that an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module cfr_bank
  import cfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bank_wr_t           wr,
  input  logic [BANK_AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [BANK_DEPTH-1:0] vld_r;
  logic                  rd_vld_r;
  logic [7:0]            ram_q;

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // flag is registered alongside the read data, so both line up
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
  end

  assign rdata = rd_vld_r ? ram_q : 8'h00;

endmodule

[hw/rtl/cfr_parser.sv]
// ----------------------------------------------------------------------------
// cfr_parser
// Byte-level frame parser: tracks the frame phase, the running sum and the
// payload count, writes every frame byte into the store banks and signals
// a completed frame on the sum byte.
// ----------------------------------------------------------------------------
module cfr_parser
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  input  logic        seq_busy,
  output bank_wr_t    wr_even,
  output bank_wr_t    wr_odd,
  output frame_done_t done
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GOT_AA,
    PH_GOT_AF,
    PH_GOT_CMD,
    PH_PAYLOAD,
    PH_SUM
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [5:0]          len_r, len_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic                acc;
  logic                wr_en;
  logic [WR_IDX_W-1:0] widx;
  logic                widx_ok;
  logic [5:0]          cnt_inc;

  // payload and sum bytes wait while the previous frame's results drain,
  // so the coefficient bytes are not overwritten before they are read
  assign in_stall = seq_busy && ((phase_r == PH_PAYLOAD) || (phase_r == PH_SUM));
  assign acc      = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + 6'd1;

  // next phase and store write
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    wr_en     = 1'b0;
    widx      = '0;
    done      = '0;
    if (acc) begin
      phase_nxt = PH_IDLE;
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == SYNC_0) begin
            phase_nxt = PH_GOT_AA;
            wr_en     = 1'b1;
            widx      = WR_IDX_W'(0);
            sum_nxt   = in_rx_byte;
          end
        end
        PH_GOT_AA: begin
          if (in_rx_byte == SYNC_1) begin
            phase_nxt = PH_GOT_AF;
            wr_en     = 1'b1;
            widx      = WR_IDX_W'(1);
            sum_nxt   = sum_r + in_rx_byte;
          end
        end
        PH_GOT_AF: begin
          if ((in_rx_byte != 8'h00) && (in_rx_byte < CMD_LIMIT)) begin
            phase_nxt = PH_GOT_CMD;
            wr_en     = 1'b1;
            widx      = WR_IDX_W'(2);
            cmd_nxt   = in_rx_byte;
            sum_nxt   = sum_r + in_rx_byte;
          end
        end
        PH_GOT_CMD: begin
          if (in_rx_byte < LEN_LIMIT) begin
            phase_nxt = PH_PAYLOAD;
            wr_en     = 1'b1;
            widx      = WR_IDX_W'(3);
            len_nxt   = in_rx_byte[5:0];
            cnt_nxt   = '0;
            sum_nxt   = sum_r + in_rx_byte;
          end
        end
        PH_PAYLOAD: begin
          // a zero-length frame ends here with the byte dropped
          if (cnt_r < len_r) begin
            phase_nxt = (cnt_inc == len_r) ? PH_SUM : PH_PAYLOAD;
            wr_en     = 1'b1;
            widx      = WR_IDX_W'(4) + cnt_r;
            cnt_nxt   = cnt_inc;
            sum_nxt   = sum_r + in_rx_byte;
          end
        end
        PH_SUM: begin
          wr_en         = 1'b1;
          widx          = WR_IDX_W'(4) + cnt_r;
          done.valid    = 1'b1;
          done.cmd      = cmd_r;
          done.sum_byte = in_rx_byte;
          done.ok       = (sum_r == in_rx_byte);
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // bank select by the low index bit, drop writes past the store
  assign widx_ok = IDX_CMP_W'(widx) < IDX_CMP_W'(FRAME_BYTES);

  always_comb begin
    wr_even      = '0;
    wr_odd       = '0;
    wr_even.addr = BANK_AW'(widx[WR_IDX_W-1:1]);
    wr_odd.addr  = BANK_AW'(widx[WR_IDX_W-1:1]);
    wr_even.data = in_rx_byte;
    wr_odd.data  = in_rx_byte;
    wr_even.en   = wr_en && widx_ok && !widx[0];
    wr_odd.en    = wr_en && widx_ok && widx[0];
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

[hw/rtl/cfr_seq.sv]
// ----------------------------------------------------------------------------
// cfr_seq
// Result sequencer: after a completed frame it issues the acknowledge bytes,
// the verdict and, for a good gain command, nine coefficient writes read
// from the store banks, through one output register.
// ----------------------------------------------------------------------------
module cfr_seq
  import cfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  frame_done_t        done,
  output logic               busy,
  output logic [BANK_AW-1:0] raddr,
  input  logic [7:0]         even_q,
  input  logic [7:0]         odd_q,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic [7:0]         out_frame_command,
  output logic               out_sum_ok,
  output logic [4:0]         out_coef_row,
  output logic [1:0]         out_coef_col,
  output logic [15:0]        out_coef_value,
  output logic               out_last
);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [7:0]        cmd_r;
  logic [7:0]        sbyte_r;
  logic              ok_r;
  logic              coef_en_r;
  logic [4:0]        row_base_r;

  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [7:0]        tx_r;
  logic [7:0]        cmd_out_r;
  logic              ok_out_r;
  logic [4:0]        row_r;
  logic [1:0]        col_r;
  logic [15:0]       value_r;
  logic              last_r;

  logic              load;
  logic [STEP_W-1:0] step_rd;
  logic [STEP_W-1:0] coef_rd;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] coef_cur;
  coef_pos_t         pos;
  logic [1:0]        kind_nxt;
  logic [7:0]        tx_nxt;
  logic [7:0]        chk;
  logic [2:0]        cmd_off;
  logic [4:0]        row_base_nxt;

  assign busy      = busy_r;
  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign last_step = coef_en_r ? STEP_COEF_LAST : STEP_VERDICT;

  // read address runs one step ahead of the output register
  assign step_rd = load ? (step_r + STEP_W'(1)) : step_r;
  assign coef_rd = step_rd - STEP_COEF_0;
  assign raddr   = (step_rd < STEP_COEF_0) ? BANK_AW'(COEF_ADDR_BASE)
                 : BANK_AW'(coef_rd[3:0]) + BANK_AW'(COEF_ADDR_BASE);

  // row base of the gain command, 3 * (cmd - 0x10)
  assign cmd_off      = 3'(done.cmd - CMD_COEF_LO);
  assign row_base_nxt = {1'b0, cmd_off, 1'b0} + {2'b00, cmd_off};

  // result fields of the current step
  assign chk      = ACK_SUM_BASE + cmd_r + sbyte_r;
  assign coef_cur = step_r - STEP_COEF_0;
  assign pos      = coef_pos(coef_cur[3:0]);

  always_comb begin
    kind_nxt = KIND_COEF;
    if (step_r < STEP_VERDICT) begin
      kind_nxt = KIND_ACK;
    end else if (step_r == STEP_VERDICT) begin
      kind_nxt = KIND_VERDICT;
    end
  end

  always_comb begin
    case (step_r)
      5'd0:         tx_nxt = ACK_HDR_0;
      5'd1:         tx_nxt = ACK_HDR_1;
      5'd2:         tx_nxt = ACK_HDR_2;
      5'd3:         tx_nxt = ACK_HDR_3;
      STEP_ACK_CMD: tx_nxt = cmd_r;
      STEP_ACK_SUM: tx_nxt = sbyte_r;
      STEP_ACK_CHK: tx_nxt = chk;
      default:      tx_nxt = 8'h00;
    endcase
  end

  // sequencer control and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (done.valid) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (load) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == last_step) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame context captured at completion
  always_ff @(posedge clk) begin
    if (done.valid) begin
      cmd_r      <= done.cmd;
      sbyte_r    <= done.sum_byte;
      ok_r       <= done.ok;
      coef_en_r  <= done.ok && (done.cmd >= CMD_COEF_LO) && (done.cmd <= CMD_COEF_HI);
      row_base_r <= row_base_nxt;
    end
  end

  // output register, frame context included so a held result stays whole
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= kind_nxt;
      tx_r      <= tx_nxt;
      cmd_out_r <= cmd_r;
      ok_out_r  <= ok_r;
      last_r    <= (step_r == last_step);
      if (kind_nxt == KIND_COEF) begin
        row_r   <= row_base_r + {3'b000, pos.row_off};
        col_r   <= pos.col;
        value_r <= {even_q, odd_q};
      end else begin
        row_r   <= '0;
        col_r   <= '0;
        value_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_tx_byte       = tx_r;
  assign out_frame_command = cmd_out_r;
  assign out_sum_ok        = ok_out_r;
  assign out_coef_row      = row_r;
  assign out_coef_col      = col_r;
  assign out_coef_value    = value_r;
  assign out_last          = last_r;

endmodule

[hw/rtl/command_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Serial command frame receiver: parses AA AF cmd len payload sum frames,
// answers with an acknowledge frame and a verdict and issues gain writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transfer, accepted one per cycle unless in_stall.
//   out_* : results of the sum byte of a frame: seven acknowledge bytes
//           (kind 0), one verdict (kind 1) and, for a matching sum on
//           commands 0x10..0x15, nine coefficient writes (kind 2); out_last
//           marks the final one. Other bytes produce no transfer.
//   The first result follows the sum byte through the sequencer state and the
//   output register; the rest follow one per cycle unless out_stall is high.
//   Frame bytes go into two byte-wide banks (even and odd index); each
//   coefficient is one read of both banks, issued one step ahead of the output.
//   While results drain, header bytes of the next frame are still taken,
//   but payload and sum bytes are held off with in_stall until the last
//   result is loaded into the output register.
//   out_stall holds the output register; the sequencer waits with it.
//   Reset clears the parser, the sequencer and the bank written flags at
//   once; an unwritten store byte reads as zero.
// ----------------------------------------------------------------------------
module command_frame_receiver_core
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [7:0]  out_frame_command,
  output logic        out_sum_ok,
  output logic [4:0]  out_coef_row,
  output logic [1:0]  out_coef_col,
  output logic [15:0] out_coef_value,
  output logic        out_last
);

  bank_wr_t           wr_even;
  bank_wr_t           wr_odd;
  frame_done_t        done;
  logic               seq_busy;
  logic [BANK_AW-1:0] raddr;
  logic [7:0]         even_q;
  logic [7:0]         odd_q;

  // byte parser
  cfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .seq_busy   (seq_busy),
    .wr_even    (wr_even),
    .wr_odd     (wr_odd),
    .done       (done)
  );

  // frame store, even and odd bytes
  cfr_bank u_bank_even (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr_even),
    .raddr (raddr),
    .rdata (even_q)
  );

  cfr_bank u_bank_odd (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr_odd),
    .raddr (raddr),
    .rdata (odd_q)
  );

  // result sequencer
  cfr_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .done              (done),
    .busy              (seq_busy),
    .raddr             (raddr),
    .even_q            (even_q),
    .odd_q             (odd_q),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_frame_command (out_frame_command),
    .out_sum_ok        (out_sum_ok),
    .out_coef_row      (out_coef_row),
    .out_coef_col      (out_coef_col),
    .out_coef_value    (out_coef_value),
    .out_last          (out_last)
  );

endmodule

[hw/rtl/cfr_checker.sv]
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks of the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_tx_byte,
  input  logic [7:0]  out_frame_command,
  input  logic        out_sum_ok,
  input  logic [4:0]  out_coef_row,
  input  logic [1:0]  out_coef_col,
  input  logic [15:0] out_coef_value,
  input  logic        out_last
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_tx_byte)
      && $stable(out_coef_value) && $stable(out_last))
    else $error("stalled result changed");

  // an acknowledge byte never ends a result run
  a_ack_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACK) |-> !out_last)
    else $error("acknowledge byte marked last");

  // a bad-sum verdict closes the run
  a_bad_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_VERDICT) && !out_sum_ok |-> out_last)
    else $error("bad-sum verdict not last");

  // coefficient writes only for good gain commands
  a_coef_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_COEF) |-> out_sum_ok
      && (out_frame_command >= CMD_COEF_LO) && (out_frame_command <= CMD_COEF_HI))
    else $error("coefficient write for wrong frame");

  // a taken acknowledge byte is followed by more of the same run
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_ACK) |=> out_valid)
    else $error("result run broken after acknowledge byte");

endmodule

bind command_frame_receiver_core cfr_checker u_cfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_tx_byte       (out_tx_byte),
  .out_frame_command (out_frame_command),
  .out_sum_ok        (out_sum_ok),
  .out_coef_row      (out_coef_row),
  .out_coef_col      (out_coef_col),
  .out_coef_value    (out_coef_value),
  .out_last          (out_last)
);

[test/frame_reply_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_reply_checker
// Watches the byte and result channels of the command frame receiver, parses
// every accepted byte with its own frame parser, queues the acknowledge,
// verdict and gain write replies it predicts and compares each result
// transfer, field by field, against the oldest queued reply.
// ----------------------------------------------------------------------------
module frame_reply_checker
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_tx_byte,
  input  logic [7:0]  out_frame_command,
  input  logic        out_sum_ok,
  input  logic [4:0]  out_coef_row,
  input  logic [1:0]  out_coef_col,
  input  logic [15:0] out_coef_value,
  input  logic        out_last,
  output int          mismatch_count,
  output int          replies_pending
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GOT_SYNC0,
    PH_GOT_SYNC1,
    PH_GOT_CMD,
    PH_PAYLOAD,
    PH_SUM
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  cmd;
    logic        sum_ok;
    logic [4:0]  row;
    logic [1:0]  col;
    logic [15:0] value;
    logic        last;
  } frame_reply_t;

  parse_phase_e phase;
  logic [5:0]   pay_len;
  logic [5:0]   pay_cnt;
  logic [7:0]   run_sum;
  logic [7:0]   cur_cmd;
  logic [7:0]   frame_mem [FRAME_BYTES];
  frame_reply_t frame_replies [$];

  // writes past the end of the store are lost
  task automatic store_byte(input int idx, input logic [7:0] b);
    if (idx < FRAME_BYTES) begin
      frame_mem[idx] = b;
    end
  endtask

  // advance the frame parser by one byte and queue the replies it causes
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_reply_t r;
    logic         ok;
    logic         gains;
    logic [7:0]   ack [7];
    int           idx;
    if (phase == PH_IDLE && b == SYNC_0) begin
      phase = PH_GOT_SYNC0;
      store_byte(0, b);
      run_sum = b;
    end else if (phase == PH_GOT_SYNC0 && b == SYNC_1) begin
      phase = PH_GOT_SYNC1;
      store_byte(1, b);
      run_sum = run_sum + b;
    end else if (phase == PH_GOT_SYNC1 && b != 8'h00 && b < CMD_LIMIT) begin
      phase = PH_GOT_CMD;
      store_byte(2, b);
      cur_cmd = b;
      run_sum = run_sum + b;
    end else if (phase == PH_GOT_CMD && b < LEN_LIMIT) begin
      phase = PH_PAYLOAD;
      store_byte(3, b);
      pay_len = b[5:0];
      pay_cnt = '0;
      run_sum = run_sum + b;
    end else if (phase == PH_PAYLOAD && pay_cnt < pay_len) begin
      store_byte(4 + int'(pay_cnt), b);
      pay_cnt = pay_cnt + 6'd1;
      run_sum = run_sum + b;
      if (pay_cnt == pay_len) begin
        phase = PH_SUM;
      end
    end else if (phase == PH_SUM) begin
      ok    = (run_sum == b);
      gains = ok && cur_cmd >= CMD_COEF_LO && cur_cmd <= CMD_COEF_HI;
      phase = PH_IDLE;
      store_byte(4 + int'(pay_cnt), b);
      ack = '{ACK_HDR_0, ACK_HDR_1, ACK_HDR_2, ACK_HDR_3, cur_cmd, b,
              8'(ACK_SUM_BASE + cur_cmd + b)};
      // acknowledge frame bytes
      for (int i = 0; i < 7; i++) begin
        r         = '0;
        r.kind    = KIND_ACK;
        r.tx_byte = ack[i];
        r.cmd     = cur_cmd;
        r.sum_ok  = ok;
        frame_replies.push_back(r);
      end
      // verdict closes the frame unless gain writes follow
      r        = '0;
      r.kind   = KIND_VERDICT;
      r.cmd    = cur_cmd;
      r.sum_ok = ok;
      r.last   = !gains;
      frame_replies.push_back(r);
      // nine big-endian gain words out of the frame store
      if (gains) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            idx      = 6 * i + 2 * j + 4;
            r        = '0;
            r.kind   = KIND_COEF;
            r.cmd    = cur_cmd;
            r.sum_ok = ok;
            r.row    = 5'(3 * int'(cur_cmd - CMD_COEF_LO) + i);
            r.col    = 2'(j);
            r.value  = {frame_mem[idx], frame_mem[idx + 1]};
            r.last   = (i == 2 && j == 2);
            frame_replies.push_back(r);
          end
        end
      end
    end else begin
      phase = PH_IDLE;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare one result transfer with the oldest queued reply
  task automatic check_reply();
    frame_reply_t want;
    if (frame_replies.size() == 0) begin
      $display("%0t: result with none expected, kind %0h tx %0h cmd %0h", $time,
               out_kind, out_tx_byte, out_frame_command);
      mismatch_count++;
    end else begin
      want = frame_replies.pop_front();
      check_field("kind", 16'(want.kind), 16'(out_kind));
      check_field("tx_byte", 16'(want.tx_byte), 16'(out_tx_byte));
      check_field("frame_command", 16'(want.cmd), 16'(out_frame_command));
      check_field("sum_ok", 16'(want.sum_ok), 16'(out_sum_ok));
      check_field("coef_row", 16'(want.row), 16'(out_coef_row));
      check_field("coef_col", 16'(want.col), 16'(out_coef_col));
      check_field("coef_value", want.value, out_coef_value);
      check_field("last", 16'(want.last), 16'(out_last));
    end
  endtask

  // byte transfer is parsed before the result transfer of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      phase          = PH_IDLE;
      pay_len        = '0;
      pay_cnt        = '0;
      run_sum        = '0;
      cur_cmd        = '0;
      mismatch_count = 0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        frame_mem[k] = '0;
      end
      frame_replies.delete();
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        check_reply();
      end
    end
    replies_pending = frame_replies.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the command frame receiver: a few directed
// frames and malformed headers, then mostly well-formed random frames with
// some corrupted frames and noise. Both sides idle at random; the result side
// also holds off for a long stretch and the byte side pauses once until all
// replies are out. Checking is done by frame_reply_checker.
// ----------------------------------------------------------------------------
module testbench;
  import cfr_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_PCT     = 9;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 60;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic [7:0]  out_frame_command;
  logic        out_sum_ok;
  logic [4:0]  out_coef_row;
  logic [1:0]  out_coef_col;
  logic [15:0] out_coef_value;
  logic        out_last;
  int          mismatches;
  int          pending;

  bit quiet;
  int frame_items;
  int hold_left;
  bit hold_done;
  int idle_cycles;

  command_frame_receiver_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_frame_command (out_frame_command),
    .out_sum_ok        (out_sum_ok),
    .out_coef_row      (out_coef_row),
    .out_coef_col      (out_coef_col),
    .out_coef_value    (out_coef_value),
    .out_last          (out_last)
  );

  frame_reply_checker reply_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_frame_command (out_frame_command),
    .out_sum_ok        (out_sum_ok),
    .out_coef_row      (out_coef_row),
    .out_coef_col      (out_coef_col),
    .out_coef_value    (out_coef_value),
    .out_last          (out_last),
    .mismatch_count    (mismatches),
    .replies_pending   (pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one byte, idling now and then, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // full frame; fill < 0 gives a random payload, corrupt hits one random byte
  task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_sum,
                            input bit corrupt, input int fill);
    logic [7:0] fb [$];
    logic [7:0] sum;
    fb = '{SYNC_0, SYNC_1, cmd, 8'(len)};
    for (int k = 0; k < len; k++) begin
      fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    sum = '0;
    foreach (fb[k]) sum = sum + fb[k];
    if (bad_sum) begin
      sum = sum ^ 8'(1 << $urandom_range(0, 7));
    end
    fb.push_back(sum);
    if (corrupt) begin
      fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
    end
    foreach (fb[k]) begin
      send_byte(fb[k]);
      frame_items++;
    end
  endtask

  // result side: random stalls, one long hold-off once traffic is going
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && frame_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int   start;
    int   done;
    int   r;
    bit   paused;
    logic [7:0] cmd;
    int   len;
    logic [7:0] odd_cmds [4];
    odd_cmds    = '{8'h01, 8'hF0, 8'h0F, 8'h16};
    paused      = 1'b0;
    quiet       = 1'b0;
    frame_items = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // short payload: gain words pick up the sum byte and zeros
    send_frame(CMD_COEF_LO, 2, 1'b0, 1'b0, -1);
    // zero length, highest command: next byte is dropped
    send_frame(8'hF0, 0, 1'b0, 1'b0, 0);
    // command zero, command at limit, length at limit
    send_byte(SYNC_0); send_byte(SYNC_1); send_byte(8'h00);
    send_byte(SYNC_0); send_byte(SYNC_1); send_byte(CMD_LIMIT);
    send_byte(SYNC_0); send_byte(SYNC_1); send_byte(8'h01); send_byte(LEN_LIMIT);
    // second sync byte wrong, even though it is a sync value
    send_byte(SYNC_0); send_byte(SYNC_0);
    // bad sum on a gain command with an all-ones payload
    send_frame(CMD_COEF_HI, 1, 1'b1, 1'b0, 8'hFF);

    // random frames, corrupted frames and noise
    start = frame_items;
    while (frame_items - start < RANDOM_ITEMS) begin
      done  = frame_items - start;
      quiet = (done >= 120 && done < 220);
      if (!paused && done >= 300) begin
        // let every reply drain before going on
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      r = $urandom_range(0, 9);
      if (r < 5)      cmd = 8'($urandom_range(CMD_COEF_LO, CMD_COEF_HI));
      else if (r < 8) cmd = 8'($urandom_range(1, CMD_LIMIT - 1));
      else            cmd = odd_cmds[$urandom_range(0, 3)];
      r = $urandom_range(0, 9);
      if (r < 5)      len = $urandom_range(18, 24);
      else if (r < 8) len = $urandom_range(0, 17);
      else if (r < 9) len = $urandom_range(25, 49);
      else            len = 49;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(cmd, len, $urandom_range(0, 99) < 15, 1'b0, -1);
      end else if (r < 88) begin
        send_frame(cmd, len, 1'b0, 1'b1, -1);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
    quiet = 1'b0;

    // drain and verdict
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
